// ===== design/djc_pkg.sv =====
// ----------------------------------------------------------------------------
// djc_pkg
// Types and fixed-point constants shared by the disparity colormap block.
// ----------------------------------------------------------------------------
`default_nettype none

package djc_pkg;

  typedef struct packed {
    logic signed [19:0] disparity;
    logic               unknown;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // configuration register indexes
  localparam logic [1:0] CfgOffset = 2'd0;
  localparam logic [1:0] CfgGain   = 2'd1;
  localparam logic [1:0] CfgJet    = 2'd2;

  // scaled value 1.0 in q.20
  localparam logic [44:0] OneQ20 = 45'd1048576;

  // clamped ends of the mapping, q.16
  localparam logic [16:0] XLow  = 17'd3704;
  localparam logic [16:0] XHigh = 17'd66391;

  // x = (50*v + NumBias) / 920, done as a reciprocal multiply
  localparam logic [25:0] NumBias    = 26'd6029772;
  localparam logic [25:0] NumGain    = 26'd50;
  localparam logic [51:0] Recip920   = 52'd37347542;
  localparam int          RecipShift = 35;

  // channel centers, q.16
  localparam logic [16:0] CenterRed   = 17'd49152;
  localparam logic [16:0] CenterGreen = 17'd32768;
  localparam logic [16:0] CenterBlue  = 17'd16384;

  // 1.5 in q.16
  localparam logic signed [19:0] TPeak = 20'sd98304;

endpackage

`default_nettype wire

// ===== design/djc_chan.sv =====
// ----------------------------------------------------------------------------
// djc_chan
// One color channel: triangle 1.5-4|x-c|, scale by 255, round and clamp.
// Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module djc_chan (
  input  wire logic        clk,
  input  wire logic [16:0] x,
  input  wire logic [16:0] center,
  input  wire logic        blank,
  output logic      [7:0]  chan
);
  import djc_pkg::*;

  logic [16:0]        delta;
  logic signed [19:0] tri_val;
  logic [16:0]        tpos_nxt;
  logic [16:0]        tpos_r;
  logic [24:0]        prod;
  logic [25:0]        rounded;
  logic [8:0]         quant;
  logic [7:0]         chan_nxt;
  logic [7:0]         chan_r;

  always_comb begin
    delta   = (x >= center) ? (x - center) : (center - x);
    tri_val = TPeak - $signed({1'b0, delta, 2'b00});
    // a zero triangle value rounds to zero, which also serves for black
    if (blank || tri_val[19] || (tri_val == 20'sd0)) begin
      tpos_nxt = 17'd0;
    end else begin
      tpos_nxt = tri_val[16:0];
    end
  end

  always_ff @(posedge clk) begin
    tpos_r <= tpos_nxt;
  end

  always_comb begin
    prod    = {tpos_r, 8'd0} - {8'd0, tpos_r};
    rounded = {1'b0, prod} + 26'd32768;
    quant   = rounded[24:16];
    chan_nxt = quant[8] ? 8'd255 : quant[7:0];
  end

  always_ff @(posedge clk) begin
    chan_r <= chan_nxt;
  end

  assign chan = chan_r;

endmodule

`default_nettype wire

// ===== design/disparity_jet_colormap.sv =====
// ----------------------------------------------------------------------------
// disparity_jet_colormap
// Maps one disparity pixel to an RGB color with a shifted jet colormap.
// Throughput: one pixel per clock; busy stays low, start is taken every cycle.
// The 21x25 gain multiply and the 26x26 reciprocal multiply each own a stage.
// Reset clears the pipeline valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module disparity_jet_colormap (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire djc_pkg::pixel_t in_data,
  output logic                out_valid,
  output djc_pkg::rgb_t       out_data,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [23:0]    cfg_wdata
);
  import djc_pkg::*;

  // configuration
  logic signed [19:0] offset_r;
  logic [23:0]        gain_r;
  logic               jet_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= 20'sd0;
      gain_r   <= 24'd64;
      jet_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgOffset: offset_r <= $signed(cfg_wdata[19:0]);
        CfgGain:   gain_r   <= cfg_wdata;
        CfgJet:    jet_r    <= cfg_wdata[0];
        default:   ;
      endcase
    end
  end

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // valid bits travel with the data through all seven stages
  logic [6:0] vld_r;
  logic [6:0] vld_nxt;
  assign vld_nxt = {vld_r[5:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 7'd0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // black flag, stages 1..5
  logic [4:0] blk_r;
  logic [4:0] blk_nxt;
  assign blk_nxt = {blk_r[3:0], in_data.unknown || !jet_r};

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

  // stage 1: difference
  logic signed [20:0] diff_nxt;
  logic signed [20:0] diff_r;
  assign diff_nxt = 21'(in_data.disparity) - 21'(offset_r);

  // stage 2: scaled value, q.20
  logic signed [45:0] v_nxt;
  logic signed [45:0] v_r;
  assign v_nxt = 46'(diff_r) * $signed({22'd0, gain_r});

  // stage 3: range check and numerator
  logic        lo_nxt;
  logic        hi_nxt;
  logic [25:0] num_nxt;
  logic        lo_r;
  logic        hi_r;
  logic [25:0] num_r;

  always_comb begin
    lo_nxt  = v_r[45];
    hi_nxt  = !v_r[45] && (v_r[44:0] > OneQ20);
    num_nxt = 26'(v_r[20:0]) * NumGain + NumBias;
  end

  // stage 4: reciprocal product, exact for the numerator range
  logic [51:0] quo_nxt;
  logic [51:0] quo_r;
  logic        lo4_r;
  logic        hi4_r;
  assign quo_nxt = 52'(num_r) * Recip920;

  // stage 5: x in q.16
  logic [16:0] x_nxt;
  logic [16:0] x_r;

  always_comb begin
    if (lo4_r) begin
      x_nxt = XLow;
    end else if (hi4_r) begin
      x_nxt = XHigh;
    end else begin
      x_nxt = quo_r[RecipShift +: 17];
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    v_r    <= v_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    lo4_r  <= lo_r;
    hi4_r  <= hi_r;
    x_r    <= x_nxt;
  end

  // stages 6 and 7: channels
  djc_chan u_red (
    .clk    (clk),
    .x      (x_r),
    .center (CenterRed),
    .blank  (blk_r[4]),
    .chan   (out_data.red)
  );

  djc_chan u_green (
    .clk    (clk),
    .x      (x_r),
    .center (CenterGreen),
    .blank  (blk_r[4]),
    .chan   (out_data.green)
  );

  djc_chan u_blue (
    .clk    (clk),
    .x      (x_r),
    .center (CenterBlue),
    .blank  (blk_r[4]),
    .chan   (out_data.blue)
  );

  assign out_valid = vld_r[6];

endmodule

`default_nettype wire

// ===== design/djc_checker.sv =====
// ----------------------------------------------------------------------------
// djc_checker
// Port-level checks on the disparity colormap, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module djc_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            start,
  input wire logic            busy,
  input wire djc_pkg::pixel_t in_data,
  input wire logic            out_valid,
  input wire djc_pkg::rgb_t   out_data,
  input wire logic            cfg_we,
  input wire logic [1:0]      cfg_index,
  input wire logic [23:0]     cfg_wdata
);
  import djc_pkg::*;

  // every transfer in gives a result with out_valid high
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##7 out_valid)
    else $error("result missing seven cycles after transfer in");

  // no result without a matching transfer in before it
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 7))
    else $error("result without matching transfer in");

  // an unknown pixel comes out black
  a_unknown_black: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.unknown) |-> ##7 (out_data == '0))
    else $error("unknown pixel not black");

  // jet mode off gives black
  a_jet_off_black: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == CfgJet) && !cfg_wdata[0]) ##1
    (start && !busy && !(cfg_we && (cfg_index == CfgJet)))
    |-> ##7 (out_data == '0))
    else $error("pixel not black with jet mode off");

endmodule

bind disparity_jet_colormap djc_checker u_djc_checker (.*);

`default_nettype wire

// ===== sim/disparity_jet_colormap_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// disparity_jet_colormap_tb
// Streams disparity pixels through the colormap block under several register
// settings and compares every color against a fixed-point model of the map.
// ----------------------------------------------------------------------------

module disparity_jet_colormap_tb;
  import djc_pkg::*;

  localparam int     ItemCount   = 750;
  localparam int     ResetCycles = 10;
  localparam int     TailCycles  = 30;
  localparam int     MaxGap      = 17;
  localparam int     ReportMax   = 10;
  localparam longint CycleLimit  = 200000;

  // no register behind this index
  localparam logic [1:0] CfgNone = 2'd3;

  // ramp constants, q.16 unless noted
  localparam longint RampLow   = 3704;
  localparam longint RampHigh  = 66391;
  localparam longint UnitQ20   = 1048576;
  localparam longint RampBias  = 6029772;
  localparam longint PeakQ16   = 98304;
  localparam longint RedQ16    = 49152;
  localparam longint GreenQ16  = 32768;
  localparam longint BlueQ16   = 16384;

  typedef enum logic [1:0] {
    WorkPixel,
    WorkWrite,
    WorkDrain
  } work_kind_t;

  typedef struct {
    work_kind_t  kind;
    pixel_t      pix;
    int          gap;
    logic [1:0]  index;
    logic [23:0] wdata;
  } work_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  pixel_t      in_data;
  logic        out_valid;
  rgb_t        out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_wdata;

  disparity_jet_colormap u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  work_t  work_q[$];
  rgb_t   color_q[$];

  // register copies seen by the color model
  logic signed [19:0] col_offset;
  logic        [23:0] col_gain;
  logic               col_jet;

  // register copies used while planning stimulus
  logic signed [19:0] plan_offset;
  logic        [23:0] plan_gain;
  int                 idle_mode;

  work_t  cur_work;
  bit     have_work;
  int     gap_left;
  logic   xfer_seen;

  int     fail_cnt;
  int     checked_cnt;
  int     pixel_cnt;
  int     unknown_cnt;
  int     write_cnt;
  longint cycle_cnt;

  always #6 clk = ~clk;

  function automatic logic [7:0] ramp_level(longint x, longint c);
    longint d;
    longint n;
    longint r;
    d = (x > c) ? x - c : c - x;
    n = 255 * (PeakQ16 - 4 * d);
    if (n <= 0) return 8'd0;
    r = (n + 32768) >>> 16;
    if (r > 255) r = 255;
    return r[7:0];
  endfunction

  function automatic rgb_t jet_color(pixel_t p);
    rgb_t   c;
    longint diff;
    longint v;
    longint x;
    c = '0;
    if (p.unknown || !col_jet) return c;
    diff = longint'($signed(p.disparity)) - longint'(col_offset);
    v = diff * longint'(col_gain);
    if (v < 0) x = RampLow;
    else if (v > UnitQ20) x = RampHigh;
    else x = (50 * v + RampBias) / 920;
    c.red   = ramp_level(x, RedQ16);
    c.green = ramp_level(x, GreenQ16);
    c.blue  = ramp_level(x, BlueQ16);
    return c;
  endfunction

  function automatic int draw_gap();
    case (idle_mode)
      0:       return 0;
      1:       return $urandom_range(0, MaxGap);
      default: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, MaxGap) : 0;
    endcase
  endfunction

  task automatic add_pixel(logic [19:0] disp, logic unk);
    work_t w;
    w = '{kind: WorkPixel, default: '0};
    w.pix.disparity = disp;
    w.pix.unknown = unk;
    w.gap = draw_gap();
    work_q.push_back(w);
  endtask

  task automatic add_write(logic [1:0] idx, logic [23:0] data);
    work_t w;
    w = '{kind: WorkWrite, default: '0};
    w.index = idx;
    w.wdata = data;
    work_q.push_back(w);
    if (idx == CfgOffset) plan_offset = data[19:0];
    if (idx == CfgGain) plan_gain = data;
  endtask

  task automatic add_drain();
    work_t w;
    w = '{kind: WorkDrain, default: '0};
    work_q.push_back(w);
  endtask

  // mostly disparities whose scaled value lands on the ramp or just past it
  function automatic logic [19:0] pick_disparity(logic signed [19:0] ofs, logic [23:0] gain);
    longint span;
    longint diff;
    logic [19:0] d;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3 || gain == 0) return 20'($urandom());
    span = UnitQ20 / longint'(gain);
    case ($urandom_range(0, 5))
      0:       diff = span + $urandom_range(0, 2) - 1;
      1:       diff = -longint'($urandom_range(1, 3));
      default: diff = $urandom_range(0, int'(span) + 1);
    endcase
    d = 20'(longint'(ofs) + diff);
    return d;
  endfunction

  // driver: one pending item at a time, inputs change on the falling edge
  always @(negedge clk) begin
    logic        nx_start;
    pixel_t      nx_data;
    logic        nx_we;
    logic [1:0]  nx_index;
    logic [23:0] nx_wdata;
    nx_start = start;
    nx_data  = in_data;
    nx_we    = 1'b0;
    nx_index = cfg_index;
    nx_wdata = cfg_wdata;
    if (start && xfer_seen) nx_start = 1'b0;
    if (rst_n && !nx_start) begin
      if (!have_work && work_q.size() != 0) begin
        cur_work  = work_q.pop_front();
        have_work = 1'b1;
        gap_left  = cur_work.gap;
      end
      if (have_work) begin
        case (cur_work.kind)
          WorkPixel: begin
            if (gap_left > 0) begin
              gap_left--;
            end else begin
              nx_start  = 1'b1;
              nx_data   = cur_work.pix;
              have_work = 1'b0;
            end
          end
          WorkWrite: begin
            // registers change only with the pipeline empty
            if (color_q.size() == 0) begin
              nx_we     = 1'b1;
              nx_index  = cur_work.index;
              nx_wdata  = cur_work.wdata;
              have_work = 1'b0;
            end
          end
          default: begin
            if (color_q.size() == 0) have_work = 1'b0;
          end
        endcase
      end
    end
    start     <= nx_start;
    in_data   <= nx_data;
    cfg_we    <= nx_we;
    cfg_index <= nx_index;
    cfg_wdata <= nx_wdata;
  end

  // monitor: register writes, pixel transfers and colors on the rising edge
  always @(posedge clk) begin
    rgb_t want;
    xfer_seen <= rst_n && (start === 1'b1) && (busy === 1'b0);
    if (!rst_n) begin
      col_offset = '0;
      col_gain   = 24'd64;
      col_jet    = 1'b1;
    end else begin
      if (cfg_we === 1'b1) begin
        write_cnt++;
        case (cfg_index)
          CfgOffset: col_offset = cfg_wdata[19:0];
          CfgGain:   col_gain   = cfg_wdata;
          CfgJet:    col_jet    = cfg_wdata[0];
          default:   ;
        endcase
      end
      if (start === 1'b1 && busy === 1'b0) begin
        color_q.push_back(jet_color(in_data));
        pixel_cnt++;
        if (in_data.unknown) unknown_cnt++;
      end
      if (out_valid === 1'b1) begin
        if (color_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= ReportMax)
            $display("unexpected color r=%0d g=%0d b=%0d", out_data.red, out_data.green,
                     out_data.blue);
        end else begin
          want = color_q.pop_front();
          checked_cnt++;
          if (out_data.red !== want.red || out_data.green !== want.green ||
              out_data.blue !== want.blue) begin
            fail_cnt++;
            if (fail_cnt <= ReportMax)
              $display("color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       want.red, want.green, want.blue,
                       out_data.red, out_data.green, out_data.blue);
          end
        end
      end
    end
  end

  // about 800 items with their idle gaps plus drains stay far below this
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("disparity_jet_colormap_tb: errors");
      $finish;
    end
  end

  initial begin
    int planned;
    int n;
    int sel;
    logic [19:0] ofs;
    logic [23:0] gain;
    clk         = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    xfer_seen   = 1'b0;
    have_work   = 1'b0;
    gap_left    = 0;
    fail_cnt    = 0;
    checked_cnt = 0;
    pixel_cnt   = 0;
    unknown_cnt = 0;
    write_cnt   = 0;
    cycle_cnt   = 0;
    plan_offset = '0;
    plan_gain   = 24'd64;
    idle_mode   = 2;

    // reset defaults: field extremes, unknown pixels
    add_pixel(20'h80000, 1'b0);
    add_pixel(20'h7FFFF, 1'b0);
    add_pixel(20'h00000, 1'b0);
    add_pixel(20'h7FFFF, 1'b1);
    add_pixel(20'h80000, 1'b1);
    // unit gain: disparity 16 reaches the top of the ramp
    add_write(CfgGain, 24'h010000);
    for (int i = 0; i <= 15; i += 3) add_pixel(20'(i), 1'b0);
    add_pixel(20'd16, 1'b0);
    add_pixel(20'd17, 1'b0);
    // zero gain, offset at its top, junk in the unused upper bits
    add_write(CfgOffset, 24'hF7FFFF);
    add_write(CfgGain, 24'h000000);
    add_pixel(20'h80000, 1'b0);
    add_pixel(20'h12345, 1'b0);
    // largest gain with offset at its bottom
    add_write(CfgGain, 24'hFFFFFF);
    add_write(CfgOffset, 24'h080000);
    add_pixel(20'h80000, 1'b0);
    add_pixel(20'h80001, 1'b0);
    // write to an index with no register must change nothing
    add_write(CfgNone, 24'hFFFFFF);
    add_pixel(20'h80001, 1'b0);
    // colormap off
    add_write(CfgJet, 24'hFFFFFE);
    add_pixel(20'h00010, 1'b0);
    add_pixel(20'h00010, 1'b1);
    add_write(CfgJet, 24'h000001);
    add_drain();

    planned = 0;
    while (planned < ItemCount) begin
      idle_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 2) != 0) begin
        sel = $urandom_range(0, 5);
        case (sel)
          0:       ofs = 20'h80000;
          1:       ofs = 20'h7FFFF;
          2:       ofs = 20'h00000;
          default: ofs = 20'($urandom());
        endcase
        add_write(CfgOffset, {4'($urandom()), ofs});
      end
      sel = $urandom_range(0, 9);
      case (sel)
        0:       gain = 24'h000000;
        1:       gain = 24'hFFFFFF;
        2:       gain = 24'h000001;
        3:       gain = 24'($urandom());
        default: gain = 24'($urandom_range(16, 1 << 18));
      endcase
      add_write(CfgGain, gain);
      if ($urandom_range(0, 2) == 0)
        add_write(CfgJet, {23'($urandom()), ($urandom_range(0, 5) != 0)});
      else if (sel == 0)
        add_write(CfgJet, 24'h000001);
      if ($urandom_range(0, 19) == 0) add_write(CfgNone, 24'($urandom()));
      n = $urandom_range(10, 60);
      for (int k = 0; k < n; k++) begin
        add_pixel(pick_disparity(plan_offset, plan_gain), $urandom_range(0, 9) == 0);
        if ($urandom_range(0, 99) == 0) add_drain();
      end
      planned += n;
    end
    add_write(CfgJet, 24'h000001);

    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (work_q.size() != 0 || have_work || start || color_q.size() != 0)
      @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("covered %0d pixels (%0d unknown) over %0d register writes",
             pixel_cnt, unknown_cnt, write_cnt);
    $display("%0d colors compared, %0d failures", checked_cnt, fail_cnt);
    if (fail_cnt == 0 && color_q.size() == 0) begin
      $display("disparity_jet_colormap_tb: clean");
    end else begin
      $display("disparity_jet_colormap_tb: errors");
    end
    $finish;
  end

endmodule
